>>> design/trs_pkg.sv
package trs_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int QUAT_FRAC_BITS  = 14;

    localparam int COORD_W = 32;
    localparam int QUAT_W  = 16;
    localparam int CFG_W   = 32;

    localparam int SCALED_LIMIT_LOG2 = 38;
    localparam int SCALED_W          = SCALED_LIMIT_LOG2 + 2;

    localparam int NUM_REGS  = 8;
    localparam int CFG_IDX_W = $clog2(NUM_REGS);

    localparam logic [CFG_IDX_W-1:0] REG_TRANSLATE_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TRANSLATE_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_TRANSLATE_Z = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_WX     = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_QUAT_YZ     = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_X     = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y     = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Z     = CFG_IDX_W'(7);

    localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        32'h4000_0000, 32'h0000_0000,
        32'h0001_0000, 32'h0001_0000, 32'h0001_0000
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } t_point;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic                      overflow;
    } t_result;

endpackage

>>> design/trs_quat_matrix.sv
module trs_quat_matrix #(
    parameter int QUAT_FRAC_BITS = trs_pkg::QUAT_FRAC_BITS,
    localparam int MAT_W = 2 * trs_pkg::QUAT_W + 3 - QUAT_FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [trs_pkg::CFG_W-1:0]    i_quat_wx,
    input  logic [trs_pkg::CFG_W-1:0]    i_quat_yz,
    output logic [8:0][MAT_W-1:0]        o_mat
);

    localparam int QW    = trs_pkg::QUAT_W;
    localparam int PW    = 2 * QW;
    localparam int RAW_W = 2 * QW + 3;
    localparam logic signed [RAW_W-1:0] ONE =
        {{(RAW_W-1){1'b0}}, 1'b1} << (2 * QUAT_FRAC_BITS);

    logic signed [QW-1:0] w, x, y, z;
    logic signed [PW-1:0] r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    logic signed [RAW_W-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
    logic signed [RAW_W-1:0] n_raw [9];
    logic [MAT_W-1:0] r_mat [9];

    assign w = $signed(i_quat_wx[2*QW-1:QW]);
    assign x = $signed(i_quat_wx[QW-1:0]);
    assign y = $signed(i_quat_yz[2*QW-1:QW]);
    assign z = $signed(i_quat_yz[QW-1:0]);

    always_ff @(posedge i_clk) begin
        r_xx <= PW'(x) * PW'(x);
        r_yy <= PW'(y) * PW'(y);
        r_zz <= PW'(z) * PW'(z);
        r_xy <= PW'(x) * PW'(y);
        r_xz <= PW'(x) * PW'(z);
        r_yz <= PW'(y) * PW'(z);
        r_wx <= PW'(w) * PW'(x);
        r_wy <= PW'(w) * PW'(y);
        r_wz <= PW'(w) * PW'(z);
    end

    assign xx = RAW_W'(r_xx);
    assign yy = RAW_W'(r_yy);
    assign zz = RAW_W'(r_zz);
    assign xy = RAW_W'(r_xy);
    assign xz = RAW_W'(r_xz);
    assign yz = RAW_W'(r_yz);
    assign wx = RAW_W'(r_wx);
    assign wy = RAW_W'(r_wy);
    assign wz = RAW_W'(r_wz);

    always_comb begin
        n_raw[0] = ONE - ((yy + zz) <<< 1);
        n_raw[1] = (xy - wz) <<< 1;
        n_raw[2] = (xz + wy) <<< 1;
        n_raw[3] = (xy + wz) <<< 1;
        n_raw[4] = ONE - ((xx + zz) <<< 1);
        n_raw[5] = (yz - wx) <<< 1;
        n_raw[6] = (xz - wy) <<< 1;
        n_raw[7] = (yz + wx) <<< 1;
        n_raw[8] = ONE - ((xx + yy) <<< 1);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++) begin
            r_mat[k] <= MAT_W'(n_raw[k] >>> QUAT_FRAC_BITS);
        end
    end

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            o_mat[k] = r_mat[k];
        end
    end

    a_identity_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_quat_wx, 2) == trs_pkg::CFG_RESET[trs_pkg::REG_QUAT_WX]
         && $past(i_quat_yz, 2) == '0)
        |-> (o_mat[0] == MAT_W'(1 << QUAT_FRAC_BITS) && o_mat[1] == '0
             && o_mat[5] == '0))
        else $error("identity quaternion did not give a unit diagonal");

endmodule

>>> design/trs_point_transform_core.sv
// Channel   Ports                                   Handshake
// point     start, busy, i_point                    taken when start && !busy
// result    o_valid, o_result                       one result per item, no hold-off
// config    i_cfg_we, i_cfg_idx, i_cfg_data         written when i_cfg_we is high
//
// One item per cycle; each taken item yields one result.
// There are six register stages: point capture, scale multiply,
// shift and clamp, rotation multiply, row sum, translate and saturate.
// busy stays low; the rotation matrix follows the quaternion registers through
// a product register and a matrix register, ahead of the stage that uses it.
// Reset is synchronous, clears the valid bits and loads the register defaults.
module trs_point_transform_core #(
    parameter int COORD_FRAC_BITS = trs_pkg::COORD_FRAC_BITS,
    parameter int QUAT_FRAC_BITS  = trs_pkg::QUAT_FRAC_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  trs_pkg::t_point                 i_point,
    output logic                            o_valid,
    output trs_pkg::t_result                o_result,
    input  logic                            i_cfg_we,
    input  logic [trs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [trs_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int LAT    = 6;
    localparam int CW     = trs_pkg::COORD_W;
    localparam int SW     = trs_pkg::SCALED_W;
    localparam int MAT_W  = 2 * trs_pkg::QUAT_W + 3 - QUAT_FRAC_BITS;
    localparam int PROD_W = MAT_W + SW;
    localparam int ACC_W  = PROD_W + 2;
    localparam int SUM_W  = ACC_W - QUAT_FRAC_BITS;
    localparam int V_W    = SUM_W + 1;

    localparam logic signed [2*CW-1:0] S_HI =
        {{(2*CW-1){1'b0}}, 1'b1} << trs_pkg::SCALED_LIMIT_LOG2;
    localparam logic signed [2*CW-1:0] S_LO = -S_HI;
    localparam logic signed [V_W-1:0] V_MAX = V_W'(32'sh7fff_ffff);
    localparam logic signed [V_W-1:0] V_MIN = V_W'(32'sh8000_0000);

    logic [trs_pkg::CFG_W-1:0] r_cfg [trs_pkg::NUM_REGS];
    logic [LAT-1:0] r_v;
    logic take;

    logic signed [CW-1:0]    r_pt [3];
    logic signed [CW-1:0]    sc [3];
    logic signed [CW-1:0]    tr [3];
    logic signed [2*CW-1:0]  r_sp [3];
    logic signed [2*CW-1:0]  sh [3];
    logic signed [SW-1:0]    n_s [3];
    logic signed [SW-1:0]    r_s [3];
    logic                    n_ovf2, r_ovf2, r_ovf3, r_ovf4;
    logic [8:0][MAT_W-1:0]   mat;
    logic signed [PROD_W-1:0] r_prod [3][3];
    logic signed [ACC_W-1:0] acc [3];
    logic signed [SUM_W-1:0] r_row [3];
    logic signed [V_W-1:0]   v [3];
    logic signed [CW-1:0]    n_out [3];
    logic                    n_ovf5;
    trs_pkg::t_result        r_res;

    assign busy = 1'b0;
    assign take = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < trs_pkg::NUM_REGS; k++) begin
                r_cfg[k] <= trs_pkg::CFG_RESET[k];
            end
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[LAT-2:0], take};
        end
    end

    assign sc[0] = $signed(r_cfg[trs_pkg::REG_SCALE_X]);
    assign sc[1] = $signed(r_cfg[trs_pkg::REG_SCALE_Y]);
    assign sc[2] = $signed(r_cfg[trs_pkg::REG_SCALE_Z]);
    assign tr[0] = $signed(r_cfg[trs_pkg::REG_TRANSLATE_X]);
    assign tr[1] = $signed(r_cfg[trs_pkg::REG_TRANSLATE_Y]);
    assign tr[2] = $signed(r_cfg[trs_pkg::REG_TRANSLATE_Z]);

    trs_quat_matrix #(
        .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
    ) u_matrix (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_quat_wx (r_cfg[trs_pkg::REG_QUAT_WX]),
        .i_quat_yz (r_cfg[trs_pkg::REG_QUAT_YZ]),
        .o_mat     (mat)
    );

    always_ff @(posedge i_clk) begin
        r_pt[0] <= i_point.point_x;
        r_pt[1] <= i_point.point_y;
        r_pt[2] <= i_point.point_z;
        for (int i = 0; i < 3; i++) begin
            r_sp[i] <= (2*CW)'(sc[i]) * (2*CW)'(r_pt[i]);
        end
    end

    always_comb begin
        n_ovf2 = 1'b0;
        for (int i = 0; i < 3; i++) begin
            sh[i] = r_sp[i] >>> COORD_FRAC_BITS;
            if (sh[i] < S_LO) begin
                n_s[i] = SW'(S_LO);
                n_ovf2 = 1'b1;
            end else if (sh[i] > S_HI) begin
                n_s[i] = SW'(S_HI);
                n_ovf2 = 1'b1;
            end else begin
                n_s[i] = SW'(sh[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s    <= n_s;
        r_ovf2 <= n_ovf2;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r_prod[i][j] <= PROD_W'($signed(mat[i*3+j])) * PROD_W'(r_s[j]);
            end
        end
        r_ovf3 <= r_ovf2;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i] = ACC_W'(r_prod[i][0]) + ACC_W'(r_prod[i][1])
                   + ACC_W'(r_prod[i][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_row[i] <= SUM_W'(acc[i] >>> QUAT_FRAC_BITS);
        end
        r_ovf4 <= r_ovf3;
    end

    always_comb begin
        n_ovf5 = r_ovf4;
        for (int i = 0; i < 3; i++) begin
            v[i] = V_W'(r_row[i]) + V_W'(tr[i]);
            if (v[i] > V_MAX) begin
                n_out[i] = CW'(V_MAX);
                n_ovf5   = 1'b1;
            end else if (v[i] < V_MIN) begin
                n_out[i] = CW'(V_MIN);
                n_ovf5   = 1'b1;
            end else begin
                n_out[i] = CW'(v[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.out_x    <= n_out[0];
        r_res.out_y    <= n_out[1];
        r_res.out_z    <= n_out[2];
        r_res.overflow <= n_ovf5;
    end

    assign o_valid  = r_v[LAT-1];
    assign o_result = r_res;

    a_item_emerges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> ##LAT o_valid)
        else $error("accepted item did not produce a result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(take, LAT))
        else $error("result without a matching item");

    a_busy_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(o_valid) && $past(start) |-> !busy)
        else $error("busy raised while the pipeline was streaming");

endmodule
